[rtl/hbr_pkg.sv]
// Shared types, codes and constants for the dual H-bridge speed ramp core.
// Holds the transfer payload structs, configuration struct and the duty lookup table.
// No dependencies.
`default_nettype none

package hbr_pkg;

   // Fixed design constants
   localparam int PWM_FULL         = 4095;
   localparam int SPEED_FULL       = 100;
   localparam int STOP_PAUSE_TICKS = 100;
   localparam int RAMP_STEP        = 2;

   localparam int DUTY_W = 12;
   localparam int SIDX_W = $clog2(SPEED_FULL + 1);

   // Direction codes
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BACK = 2'd2;
   localparam logic [1:0] DIR_KEEP = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_SMOOTH_ENABLE = 2'd0;
   localparam logic [1:0] CSR_STEP_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_FLOOR_SPEED   = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_DOWN  = 4'b0010,
      PH_PAUSE = 4'b0100,
      PH_UP    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       func;
      logic       motor_sel;
      logic [1:0] direction;
      logic [7:0] speed;
      logic       smooth;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] a_duty;
      logic              a_in1;
      logic              a_in2;
      logic [DUTY_W-1:0] b_duty;
      logic              b_in1;
      logic              b_in2;
      logic              a_busy;
      logic              b_busy;
   } rsp_type;

   typedef struct packed {
      logic        smooth_enable;
      logic [15:0] step_interval_ticks;
      logic [6:0]  floor_speed;
   } cfg_type;

   // One motor's work for the current transfer
   typedef struct packed {
      logic       tick;
      logic       cmd;
      logic [1:0] direction;
      logic [7:0] speed;
      logic       smooth;
   } evt_type;

   // Motor state after the current transfer, as seen on the result
   typedef struct packed {
      logic [1:0] dir;
      logic [7:0] speed;
      logic       busy;
   } view_type;

   typedef logic [SPEED_FULL:0][DUTY_W-1:0] duty_tab_type;

   function automatic duty_tab_type build_duty_table();
      duty_tab_type t;
      for (int i = 0; i <= SPEED_FULL; i++) begin
         t[i] = DUTY_W'((i * PWM_FULL) / SPEED_FULL);
      end
      return t;
   endfunction

   localparam duty_tab_type DUTY_TABLE = build_duty_table();

   // Duty for a direction and speed; zero unless driving
   function automatic logic [DUTY_W-1:0] duty_of(logic [1:0] dir, logic [7:0] speed);
      logic [SIDX_W-1:0] idx;
      logic [DUTY_W-1:0] d;
      if (speed > 8'(SPEED_FULL)) begin
         idx = SIDX_W'(SPEED_FULL);
      end else begin
         idx = speed[SIDX_W-1:0];
      end
      if (dir == DIR_FWD || dir == DIR_BACK) begin
         d = DUTY_TABLE[idx];
      end else begin
         d = '0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/hbr_cfg_regs.sv]
// Configuration register file for the dual H-bridge speed ramp core.
// Depends on hbr_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module hbr_cfg_regs
   import hbr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SMOOTH_ENABLE: cfg_in.smooth_enable       = csr_wdata[0];
            CSR_STEP_INTERVAL: cfg_in.step_interval_ticks = csr_wdata;
            CSR_FLOOR_SPEED:   cfg_in.floor_speed         = csr_wdata[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smooth_enable       <= 1'b1;
         cfg_ff.step_interval_ticks <= 16'd20;
         cfg_ff.floor_speed         <= 7'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/hbr_motor.sv]
// One motor's ramp state and its single-pass update for a tick or a command.
// Depends on hbr_pkg for codes, phase enum and the evt/view/cfg structs.
`default_nettype none

module hbr_motor
   import hbr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  cfg_type   cfg,
   input  evt_type   evt,
   output view_type  view
);

   typedef struct packed {
      logic [1:0]  cur_dir;
      logic [7:0]  cur_speed;
      logic [1:0]  tgt_dir;
      logic [7:0]  tgt_speed;
      phase_type   phase;
      logic [15:0] hold;
      logic        q_valid;
      logic [1:0]  q_dir;
      logic [7:0]  q_speed;
   } mstate_type;

   mstate_type st_ff;
   mstate_type st_in;

   function automatic logic [15:0] ivl(cfg_type c);
      return (c.step_interval_ticks == 16'd0) ? 16'd1 : c.step_interval_ticks;
   endfunction

   function automatic mstate_type go_idle(mstate_type st);
      st.phase = PH_IDLE;
      st.hold  = '0;
      return st;
   endfunction

   // Ramp-up entry with the queue known empty
   function automatic mstate_type up_core(mstate_type st, cfg_type c);
      if (st.tgt_dir == DIR_STOP) begin
         st = go_idle(st);
      end else begin
         st.cur_dir = st.tgt_dir;
         if ({1'b0, c.floor_speed} <= st.tgt_speed) begin
            st.cur_speed = {1'b0, c.floor_speed};
            st.phase     = PH_UP;
            st.hold      = ivl(c);
         end else begin
            st.cur_speed = st.tgt_speed;
            st = go_idle(st);
         end
      end
      return st;
   endfunction

   function automatic mstate_type halt_core(mstate_type st, cfg_type c);
      st.cur_dir   = DIR_STOP;
      st.cur_speed = '0;
      if (STOP_PAUSE_TICKS == 0) begin
         st = up_core(st, c);
      end else begin
         st.phase = PH_PAUSE;
         st.hold  = 16'(STOP_PAUSE_TICKS);
      end
      return st;
   endfunction

   // Ramp start with the queue known empty
   function automatic mstate_type start_core(mstate_type st, logic [1:0] d,
                                             logic [7:0] s, cfg_type c);
      logic [1:0] rd;
      rd = (d == DIR_KEEP) ? st.cur_dir : d;
      st.tgt_dir   = rd;
      st.tgt_speed = s;
      if (st.cur_dir != DIR_STOP) begin
         if (st.cur_dir == rd && st.cur_speed == s) begin
            st = go_idle(st);
         end else if (st.cur_speed >= {1'b0, c.floor_speed}) begin
            st.phase = PH_DOWN;
            st.hold  = ivl(c);
         end else begin
            st = halt_core(st, c);
         end
      end else begin
         st = up_core(st, c);
      end
      return st;
   endfunction

   // End a ramp and launch the queued command, if any
   function automatic mstate_type finish(mstate_type st, cfg_type c);
      st = go_idle(st);
      if (st.q_valid) begin
         st.q_valid = 1'b0;
         st = start_core(st, st.q_dir, st.q_speed, c);
      end
      return st;
   endfunction

   function automatic mstate_type up_full(mstate_type st, cfg_type c);
      if (st.tgt_dir == DIR_STOP) begin
         st = finish(st, c);
      end else begin
         st.cur_dir = st.tgt_dir;
         if ({1'b0, c.floor_speed} <= st.tgt_speed) begin
            st.cur_speed = {1'b0, c.floor_speed};
            st.phase     = PH_UP;
            st.hold      = ivl(c);
         end else begin
            st.cur_speed = st.tgt_speed;
            st = finish(st, c);
         end
      end
      return st;
   endfunction

   function automatic mstate_type halt_full(mstate_type st, cfg_type c);
      st.cur_dir   = DIR_STOP;
      st.cur_speed = '0;
      if (STOP_PAUSE_TICKS == 0) begin
         st = up_full(st, c);
      end else begin
         st.phase = PH_PAUSE;
         st.hold  = 16'(STOP_PAUSE_TICKS);
      end
      return st;
   endfunction

   function automatic mstate_type advance(mstate_type st, cfg_type c);
      logic [8:0] dn;
      logic [8:0] up;
      dn = {1'b0, st.cur_speed} - 9'(RAMP_STEP);
      up = {1'b0, st.cur_speed} + 9'(RAMP_STEP);
      unique case (st.phase)
         PH_DOWN: begin
            if (!dn[8] && dn[7:0] >= {1'b0, c.floor_speed}) begin
               st.cur_speed = dn[7:0];
               st.hold      = ivl(c);
            end else begin
               st = halt_full(st, c);
            end
         end
         PH_PAUSE: begin
            st = up_full(st, c);
         end
         PH_UP: begin
            if (up <= {1'b0, st.tgt_speed}) begin
               st.cur_speed = up[7:0];
               st.hold      = ivl(c);
            end else begin
               st.cur_speed = st.tgt_speed;
               st = finish(st, c);
            end
         end
         default: begin
            st = st;
         end
      endcase
      return st;
   endfunction

   always_comb begin
      st_in = st_ff;
      if (evt.tick) begin
         if (st_ff.phase != PH_IDLE) begin
            if (st_ff.hold > 16'd1) begin
               st_in.hold = st_ff.hold - 16'd1;
            end else begin
               st_in = advance(st_ff, cfg);
            end
         end
      end else if (evt.cmd) begin
         if (evt.smooth && cfg.smooth_enable) begin
            if (st_ff.phase != PH_IDLE) begin
               // queue it; a newer command replaces an older one
               st_in.q_valid = 1'b1;
               st_in.q_dir   = evt.direction;
               st_in.q_speed = evt.speed;
            end else begin
               st_in = start_core(st_ff, evt.direction, evt.speed, cfg);
            end
         end else begin
            st_in.cur_dir   = (evt.direction == DIR_KEEP) ? st_ff.cur_dir : evt.direction;
            st_in.cur_speed = evt.speed;
            st_in.phase     = PH_IDLE;
            st_in.hold      = '0;
            st_in.q_valid   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.cur_dir   <= DIR_STOP;
         st_ff.cur_speed <= '0;
         st_ff.tgt_dir   <= DIR_STOP;
         st_ff.tgt_speed <= '0;
         st_ff.phase     <= PH_IDLE;
         st_ff.hold      <= '0;
         st_ff.q_valid   <= 1'b0;
         st_ff.q_dir     <= DIR_STOP;
         st_ff.q_speed   <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign view.dir   = st_in.cur_dir;
   assign view.speed = st_in.cur_speed;
   assign view.busy  = (st_in.phase != PH_IDLE);

endmodule

`default_nettype wire

[rtl/dual_h_bridge_speed_ramp_core.sv]
// Top level of the dual H-bridge speed ramp core.
// Depends on hbr_pkg, hbr_cfg_regs and hbr_motor.
`default_nettype none

// Dual H-bridge motor controller with speed ramping. Each request transfer is
// either a one-millisecond tick (func 0) or a command for motor A or B
// (func 1). Every request yields exactly one response transfer carrying both
// motors' PWM duty, direction lines and busy flags after that request took
// effect. The block takes one request per clock while req_stall is low: a
// request lands in the input register, and once the response register is
// free both motors' single-pass update runs and writes the response register,
// so each request passes the input register and then the response register.
// A full response register that is stalled holds the input register; the
// input side keeps taking requests whenever the input register is empty or
// moving on. A smooth command (with smooth_enable set) starts a ramp: a
// running motor steps down by two every step_interval_ticks ticks while it
// stays at or above floor_speed, stops and pauses 100 ticks, then steps up by
// two from floor_speed to the target. Commands made during a ramp are queued,
// a direct command cancels the ramp. Write configuration registers only
// while no request is in flight; csr_ready is always high.

module dual_h_bridge_speed_ramp_core
   import hbr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  req_type          req_data,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type  cfg;
   evt_type  evt_a;
   evt_type  evt_b;
   view_type view_a;
   view_type view_b;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    req_take;

   hbr_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the held request into the response register when that slot is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Split the request into per-motor work; ticks go to both motors
   always_comb begin
      evt_a.tick      = advance && !in_data_ff.func;
      evt_a.cmd       = advance && in_data_ff.func && !in_data_ff.motor_sel;
      evt_a.direction = in_data_ff.direction;
      evt_a.speed     = in_data_ff.speed;
      evt_a.smooth    = in_data_ff.smooth;
      evt_b.tick      = advance && !in_data_ff.func;
      evt_b.cmd       = advance && in_data_ff.func && in_data_ff.motor_sel;
      evt_b.direction = in_data_ff.direction;
      evt_b.speed     = in_data_ff.speed;
      evt_b.smooth    = in_data_ff.smooth;
   end

   hbr_motor u_motor_a (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .evt   (evt_a),
      .view  (view_a)
   );

   hbr_motor u_motor_b (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .evt   (evt_b),
      .view  (view_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.a_duty <= duty_of(view_a.dir, view_a.speed);
         rsp_data_ff.a_in1  <= (view_a.dir == DIR_FWD);
         rsp_data_ff.a_in2  <= (view_a.dir == DIR_BACK);
         rsp_data_ff.b_duty <= duty_of(view_b.dir, view_b.speed);
         rsp_data_ff.b_in1  <= (view_b.dir == DIR_FWD);
         rsp_data_ff.b_in2  <= (view_b.dir == DIR_BACK);
         rsp_data_ff.a_busy <= view_a.busy;
         rsp_data_ff.b_busy <= view_b.busy;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
